@@ src/pstm_pkg.sv @@
// Shared constants, types and scale tables for the pad-to-scale note mapper.
package pstm_pkg;

   // Grid geometry
   localparam int GRID_COLUMNS = 8;
   localparam int GRID_ROWS    = 6;
   localparam int PAD_COUNT    = GRID_ROWS * GRID_COLUMNS;
   localparam int MASK_BITS    = 48;

   // Scale geometry
   localparam int SCALE_LEN    = 7;
   localparam int OCTAVE_SEMIS = 12;

   // Field widths
   localparam int PAD_W     = 6;
   localparam int VEL_W     = 8;
   localparam int KEY_W     = 4;
   localparam int MODE_W    = 4;
   localparam int OCT_W     = 4;
   localparam int MASK_W    = 48;
   localparam int NOTE_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 8;

   // Internal widths
   localparam int POS_W   = 6;
   localparam int DEG_W   = 3;
   localparam int QUO_W   = 4;
   localparam int OFS_W   = 4;
   localparam int SUM_W   = 9;
   localparam int PROD_W  = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROOT        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OCTAVE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ENABLE_MASK = 2'd3;

   // Scale mode codes
   localparam logic [MODE_W-1:0] MODE_LAST_ROTATION = 4'd6;
   localparam logic [MODE_W-1:0] MODE_NAT_MINOR     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_HARM_MINOR    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_MEL_MINOR     = 4'd9;

   // Reset values
   localparam logic [OCT_W-1:0] BASE_OCTAVE_RESET = 4'd5;

   // Largest note number
   localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

   // Reciprocal of seven for six-bit operands: (v * 37) >> 8
   localparam logic [PROD_W-1:0] RECIP_SEVEN = 12'd37;

   typedef struct packed {
      logic [KEY_W-1:0]  key_root;
      logic [MODE_W-1:0] scale_mode;
      logic [OCT_W-1:0]  base_octave;
      logic [MASK_W-1:0] pad_enable_mask;
   } cfg_type;

   // Word leaving the pad decode stage
   typedef struct packed {
      logic             note_on;
      logic [POS_W-1:0] pos;
   } pad_word_type;

   // Word leaving the scale lookup stage
   typedef struct packed {
      logic             note_on;
      logic [QUO_W-1:0] oct_add;
      logic [OFS_W-1:0] offset;
   } scale_word_type;

   // Degree tables; the eighth entry only pads the table and never reaches a result
   localparam logic [OFS_W-1:0] MAJOR_TAB   [8] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0};
   localparam logic [OFS_W-1:0] NAT_MIN_TAB [8] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0};
   localparam logic [OFS_W-1:0] HARM_MIN_TAB[8] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0};
   localparam logic [OFS_W-1:0] MEL_MIN_TAB [8] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0};

   // Quotient of a six-bit value by seven
   function automatic logic [QUO_W-1:0] div_seven(input logic [POS_W-1:0] v);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(v) * RECIP_SEVEN;
      return prod[PROD_W-1:PROD_W-QUO_W];
   endfunction

   // Semitone offset above the octave of the pad for a mode and a degree
   function automatic logic [OFS_W-1:0] scale_offset(input logic [MODE_W-1:0] mode,
                                                     input logic [DEG_W-1:0]  degree);
      logic [DEG_W-1:0] rot;
      logic [DEG_W:0]   r;
      logic [DEG_W-1:0] ridx;
      logic [4:0]       wrap;
      logic [4:0]       sum;
      logic [OFS_W-1:0] res;
      rot  = (mode > MODE_MEL_MINOR) ? '0 : mode[DEG_W-1:0];
      r    = {1'b0, rot} + {1'b0, degree};
      ridx = (r >= (DEG_W+1)'(SCALE_LEN)) ? DEG_W'(r - (DEG_W+1)'(SCALE_LEN)) : r[DEG_W-1:0];
      wrap = (r >= (DEG_W+1)'(SCALE_LEN)) ? 5'(OCTAVE_SEMIS) : 5'd0;
      sum  = 5'(MAJOR_TAB[ridx]) + wrap - 5'(MAJOR_TAB[rot]);
      case (mode)
         MODE_NAT_MINOR:  res = NAT_MIN_TAB[degree];
         MODE_HARM_MINOR: res = HARM_MIN_TAB[degree];
         MODE_MEL_MINOR:  res = MEL_MIN_TAB[degree];
         default:         res = sum[OFS_W-1:0];
      endcase
      return res;
   endfunction

endpackage

@@ src/pstm_csr.sv @@
// Configuration register bank of the note mapper.
module pstm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pstm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pstm_pkg::MASK_W-1:0]     csr_data,
   output pstm_pkg::cfg_type               cfg
);

   pstm_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Pick the register addressed by an accepted write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pstm_pkg::CSR_KEY_ROOT:
               cfg_in.key_root = csr_data[pstm_pkg::KEY_W-1:0];
            pstm_pkg::CSR_SCALE_MODE:
               cfg_in.scale_mode = csr_data[pstm_pkg::MODE_W-1:0];
            pstm_pkg::CSR_BASE_OCTAVE:
               cfg_in.base_octave = csr_data[pstm_pkg::OCT_W-1:0];
            pstm_pkg::CSR_PAD_ENABLE_MASK:
               cfg_in.pad_enable_mask = csr_data;
            default:
               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_root        <= '0;
         cfg_ff.scale_mode      <= '0;
         cfg_ff.base_octave     <= pstm_pkg::BASE_OCTAVE_RESET;
         cfg_ff.pad_enable_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/pstm_pad_decode.sv @@
// First stage: grid and mask check, scale position of the pad.
module pstm_pad_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  pstm_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [pstm_pkg::PAD_W-1:0]    pad_index,
   input  logic [pstm_pkg::VEL_W-1:0]    velocity,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pstm_pkg::pad_word_type        out_word
);

   logic                          valid_ff;
   logic                          valid_in;
   pstm_pkg::pad_word_type        word_ff, word_in;
   logic [pstm_pkg::PAD_W-1:0]    row;
   logic [pstm_pkg::PAD_W-1:0]    col;
   logic [pstm_pkg::PAD_W+1:0]    pos_wide;
   logic                          in_grid;
   logic                          enabled;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Split the pad number and form 2*row - row/2 + col
   always_comb begin
      row      = pstm_pkg::PAD_W'(pad_index / pstm_pkg::GRID_COLUMNS);
      col      = pstm_pkg::PAD_W'(pad_index % pstm_pkg::GRID_COLUMNS);
      pos_wide = {1'b0, row, 1'b0} - (pstm_pkg::PAD_W+2)'(row >> 1)
                 + (pstm_pkg::PAD_W+2)'(col);
      in_grid  = (int'(pad_index) < pstm_pkg::PAD_COUNT)
                 && (int'(pad_index) < pstm_pkg::MASK_BITS);
      enabled  = in_grid && cfg.pad_enable_mask[pad_index];
      word_in.note_on = (velocity != '0);
      word_in.pos     = pos_wide[pstm_pkg::POS_W-1:0];
      valid_in = in_valid && enabled;
   end

   // Advance when the next stage can take the word; drop disabled pads
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

@@ src/pstm_scale_lookup.sv @@
// Second stage: degree and octave split, scale table lookup.
module pstm_scale_lookup (
   input  logic                      clock,
   input  logic                      reset,
   input  pstm_pkg::cfg_type         cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  pstm_pkg::pad_word_type    in_word,
   output logic                      out_valid,
   input  logic                      out_ready,
   output pstm_pkg::scale_word_type  out_word
);

   logic                             valid_ff;
   pstm_pkg::scale_word_type         word_ff, word_in;
   logic [pstm_pkg::QUO_W-1:0]       quo;
   logic [pstm_pkg::POS_W-1:0]       rem;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Divide the position by seven and look up the degree's offset
   always_comb begin
      quo = pstm_pkg::div_seven(in_word.pos);
      rem = in_word.pos - pstm_pkg::POS_W'(quo * pstm_pkg::QUO_W'(pstm_pkg::SCALE_LEN));
      word_in.note_on = in_word.note_on;
      word_in.oct_add = quo;
      word_in.offset  = pstm_pkg::scale_offset(cfg.scale_mode, rem[pstm_pkg::DEG_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

@@ src/pstm_note_out.sv @@
// Third stage: note number sum, clamp and output register.
module pstm_note_out (
   input  logic                          clock,
   input  logic                          reset,
   input  pstm_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  pstm_pkg::scale_word_type      in_word,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pstm_pkg::RSP_W-1:0]    rsp_tdata
);

   logic                          valid_ff;
   logic [pstm_pkg::RSP_W-1:0]    data_ff, data_in;
   logic [4:0]                    oct_sum;
   logic [pstm_pkg::SUM_W-1:0]    note_sum;
   logic [pstm_pkg::NOTE_W-1:0]   note;

   assign in_ready   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   // Octave times twelve as shift-add, then key and offset, clamp to the top note
   always_comb begin
      oct_sum  = 5'(cfg.base_octave) + 5'(in_word.oct_add);
      note_sum = (pstm_pkg::SUM_W'(oct_sum) << 3) + (pstm_pkg::SUM_W'(oct_sum) << 2)
                 + pstm_pkg::SUM_W'(cfg.key_root) + pstm_pkg::SUM_W'(in_word.offset);
      note     = (note_sum > pstm_pkg::SUM_W'(pstm_pkg::NOTE_MAX))
                 ? pstm_pkg::NOTE_MAX : note_sum[pstm_pkg::NOTE_W-1:0];
      data_in  = {note, in_word.note_on};
   end

   // Hold the word until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ src/pad_to_scale_note_mapper.sv @@
// Top level of the pad-to-scale note mapper.
//
//   channel | direction | ports                         | word contents
//   --------+-----------+-------------------------------+-----------------------------------
//   req     | in        | req_tvalid/tready/tdata[15:0] | pad_index[5:0], velocity[13:6]
//   rsp     | out       | rsp_tvalid/tready/tdata[7:0]  | note_on[0], note_number[7:1]
//   csr     | in        | csr_valid/ready/index/data    | key_root, scale_mode, base_octave, mask
//
// One word can be taken every cycle unless a stall on rsp has backed up to the first stage;
// a result passes through three register stages (pad decode, scale lookup, note sum and output).
// Words for disabled or off-grid pads are dropped in the first stage. Reset is synchronous,
// clears the stage valid bits and resets the configuration registers; csr_ready is always high.
// A stall on rsp holds each stage whose successor is full, and bubbles close up.
module pad_to_scale_note_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pstm_pkg::REQ_W-1:0]      req_tdata,   // pad_index[5:0], velocity[13:6], zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pstm_pkg::RSP_W-1:0]      rsp_tdata,   // note_on[0], note_number[7:1]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pstm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pstm_pkg::MASK_W-1:0]     csr_data
);

   pstm_pkg::cfg_type         cfg;
   logic                      pad_valid;
   logic                      pad_ready;
   pstm_pkg::pad_word_type    pad_word;
   logic                      scale_valid;
   logic                      scale_ready;
   pstm_pkg::scale_word_type  scale_word;

   pstm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pstm_pad_decode u_pad_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pad_index (req_tdata[pstm_pkg::PAD_W-1:0]),
      .velocity  (req_tdata[pstm_pkg::PAD_W+pstm_pkg::VEL_W-1:pstm_pkg::PAD_W]),
      .out_valid (pad_valid),
      .out_ready (pad_ready),
      .out_word  (pad_word)
   );

   pstm_scale_lookup u_scale_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (pad_valid),
      .in_ready  (pad_ready),
      .in_word   (pad_word),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_word  (scale_word)
   );

   pstm_note_out u_note_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (scale_valid),
      .in_ready   (scale_ready),
      .in_word    (scale_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ src/pstm_checker.sv @@
// Port-level checks for the note mapper, bound to the top level.
module pstm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pstm_pkg::REQ_W-1:0]      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pstm_pkg::RSP_W-1:0]      rsp_tdata,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [pstm_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [pstm_pkg::MASK_W-1:0]     csr_data
);

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // An empty output stage lets every stage advance, so the input is open
   a_open_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // A stalled result stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // A stalled result keeps its word
   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

endmodule

bind pad_to_scale_note_mapper pstm_checker u_pstm_checker (.*);

@@ dv/pad_to_scale_note_mapper_test.sv @@
// Self-checking testbench for the pad-to-scale note mapper: directed table, then random phases.
`timescale 1ns / 1ps

module pad_to_scale_note_mapper_test;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;
   localparam int MAX_REPORTS    = 10;

   // Semitone steps of each scale degree
   localparam int MAJOR_STEPS   [pstm_pkg::SCALE_LEN] = '{0, 2, 4, 5, 7, 9, 11};
   localparam int NAT_MIN_STEPS [pstm_pkg::SCALE_LEN] = '{0, 2, 3, 5, 7, 8, 10};
   localparam int HARM_MIN_STEPS[pstm_pkg::SCALE_LEN] = '{0, 2, 3, 5, 7, 8, 11};
   localparam int MEL_MIN_STEPS [pstm_pkg::SCALE_LEN] = '{0, 2, 3, 5, 7, 9, 11};

   typedef struct packed {
      logic                        note_on;
      logic [pstm_pkg::NOTE_W-1:0] note_number;
   } note_msg_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_FIXED, ROW_MODEL} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [pstm_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [pstm_pkg::MASK_W-1:0]    csr_val;
      logic [pstm_pkg::PAD_W-1:0]     pad;
      logic [pstm_pkg::VEL_W-1:0]     vel;
      logic                           has_note;
      note_msg_type                   msg;
   } pad_row_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pstm_pkg::REQ_W-1:0]     req_tdata  = '0;   // pad_index[5:0], velocity[13:6], zero
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [pstm_pkg::RSP_W-1:0]     rsp_tdata;         // note_on[0], note_number[7:1]
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [pstm_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [pstm_pkg::MASK_W-1:0]    csr_data   = '0;

   pstm_pkg::cfg_type mapper_cfg;
   note_msg_type      pending_notes[$];
   pad_row_type       dir_rows[$];
   bit                idle_on = 1'b1;
   int                errors = 0;
   int                stall_left = 0;
   int                quiet_cycles = 0;

   pad_to_scale_note_mapper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Note number of a pad under the current key, mode and octave
   function automatic logic [pstm_pkg::NOTE_W-1:0] pad_note(
         input logic [pstm_pkg::PAD_W-1:0] pad);
      int row, col, pos, degree, octave, mode, rot, note;
      row    = int'(pad) / pstm_pkg::GRID_COLUMNS;
      col    = int'(pad) % pstm_pkg::GRID_COLUMNS;
      pos    = 2 * row - row / 2 + col;
      degree = pos % pstm_pkg::SCALE_LEN;
      octave = int'(mapper_cfg.base_octave) + pos / pstm_pkg::SCALE_LEN;
      mode   = (mapper_cfg.scale_mode > pstm_pkg::MODE_MEL_MINOR)
               ? 0 : int'(mapper_cfg.scale_mode);
      if (mode <= int'(pstm_pkg::MODE_LAST_ROTATION)) begin
         rot  = mode + degree;
         note = (octave + rot / pstm_pkg::SCALE_LEN) * pstm_pkg::OCTAVE_SEMIS
              + int'(mapper_cfg.key_root)
              + MAJOR_STEPS[rot % pstm_pkg::SCALE_LEN] - MAJOR_STEPS[mode];
      end else begin
         note = octave * pstm_pkg::OCTAVE_SEMIS + int'(mapper_cfg.key_root);
         case (mode)
            int'(pstm_pkg::MODE_NAT_MINOR):  note += NAT_MIN_STEPS[degree];
            int'(pstm_pkg::MODE_HARM_MINOR): note += HARM_MIN_STEPS[degree];
            default:                         note += MEL_MIN_STEPS[degree];
         endcase
      end
      return (note > int'(pstm_pkg::NOTE_MAX)) ? pstm_pkg::NOTE_MAX : pstm_pkg::NOTE_W'(note);
   endfunction

   // Message a pad event produces, if any
   function automatic void predict_msg(input logic [pstm_pkg::PAD_W-1:0] pad,
                                       input logic [pstm_pkg::VEL_W-1:0] vel,
                                       output bit hit, output note_msg_type msg);
      hit = (int'(pad) < pstm_pkg::PAD_COUNT) && (int'(pad) < pstm_pkg::MASK_BITS)
            && mapper_cfg.pad_enable_mask[pad];
      msg.note_on     = (vel != '0);
      msg.note_number = pad_note(pad);
   endfunction

   function automatic pad_row_type csr_row(input logic [pstm_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [pstm_pkg::MASK_W-1:0] val);
      pad_row_type r;
      r = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic pad_row_type fixed_row(input logic [pstm_pkg::PAD_W-1:0] pad,
                                             input logic [pstm_pkg::VEL_W-1:0] vel,
                                             input logic has, input logic on,
                                             input logic [pstm_pkg::NOTE_W-1:0] note);
      pad_row_type r;
      r = '0;
      r.kind     = ROW_FIXED;
      r.pad      = pad;
      r.vel      = vel;
      r.has_note = has;
      r.msg      = '{note_on: on, note_number: note};
      return r;
   endfunction

   function automatic pad_row_type model_row(input logic [pstm_pkg::PAD_W-1:0] pad,
                                             input logic [pstm_pkg::VEL_W-1:0] vel);
      pad_row_type r;
      r = '0;
      r.kind = ROW_MODEL;
      r.pad  = pad;
      r.vel  = vel;
      return r;
   endfunction

   // Append one row to the directed table
   function automatic void add_row(input pad_row_type r);
      dir_rows = {dir_rows, r};
   endfunction

   // Write one register and mirror it in the predictor's copy
   task automatic write_reg(input logic [pstm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pstm_pkg::MASK_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pstm_pkg::CSR_KEY_ROOT:
            mapper_cfg.key_root    = val[pstm_pkg::KEY_W-1:0];
         pstm_pkg::CSR_SCALE_MODE:
            mapper_cfg.scale_mode  = val[pstm_pkg::MODE_W-1:0];
         pstm_pkg::CSR_BASE_OCTAVE:
            mapper_cfg.base_octave = val[pstm_pkg::OCT_W-1:0];
         default:
            mapper_cfg.pad_enable_mask = val;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one pad word; queue its note message once the word is taken
   task automatic send_pad(input logic [pstm_pkg::PAD_W-1:0] pad,
                           input logic [pstm_pkg::VEL_W-1:0] vel,
                           input bit use_fixed, input bit fixed_has,
                           input note_msg_type fixed_msg);
      int           gap;
      bit           hit;
      note_msg_type msg;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, vel, pad};
      do @(posedge clock); while (!req_tready);
      if (use_fixed) begin
         hit = fixed_has;
         msg = fixed_msg;
      end else begin
         predict_msg(pad, vel, hit, msg);
      end
      if (hit) pending_notes = {pending_notes, msg};
   endtask

   // Drop valid, wait for every queued message, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: check each word against the oldest queued message, stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_notes.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("unexpected note word: on=%0b note=%0d", rsp_tdata[0], rsp_tdata[7:1]);
               errors++;
            end else if (rsp_tdata[0] !== pending_notes[0].note_on ||
                         rsp_tdata[7:1] !== pending_notes[0].note_number) begin
               if (errors < MAX_REPORTS)
                  $display("note mismatch: expected on=%0b note=%0d, got on=%0b note=%0d",
                           pending_notes[0].note_on, pending_notes[0].note_number,
                           rsp_tdata[0], rsp_tdata[7:1]);
               errors++;
               void'(pending_notes.pop_front());
            end else begin
               void'(pending_notes.pop_front());
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            stall_left = idle_on ? $urandom_range(0, 5) : 0;
            if (stall_left > 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (stall_left <= 1) rsp_tready <= 1'b1;
            stall_left--;
         end
      end
   end

   // Watchdog: end the run when no channel moves a word for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** pad_to_scale_note_mapper: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [pstm_pkg::MASK_W-1:0] mask;
      logic [pstm_pkg::PAD_W-1:0]  pad;
      logic [pstm_pkg::VEL_W-1:0]  vel;
      mapper_cfg = '{key_root: '0, scale_mode: '0, base_octave: pstm_pkg::BASE_OCTAVE_RESET,
                     pad_enable_mask: '0};

      // Directed table: reset state, extremes, disabled and off-grid pads, modes 0, 3, 6 to 9, 12, 15
      add_row(fixed_row(6'd0, 8'd100, 1'b0, 1'b0, 7'd0));
      add_row(csr_row(pstm_pkg::CSR_PAD_ENABLE_MASK, '1));
      add_row(fixed_row(6'd0, 8'd255, 1'b1, 1'b1, 7'd60));
      add_row(fixed_row(6'd0, 8'd0, 1'b1, 1'b0, 7'd60));
      add_row(fixed_row(6'd47, 8'd1, 1'b1, 1'b1, 7'd86));
      add_row(fixed_row(6'd48, 8'd50, 1'b0, 1'b0, 7'd0));
      add_row(fixed_row(6'd63, 8'd255, 1'b0, 1'b0, 7'd0));
      add_row(model_row(6'd9, 8'd127));
      add_row(model_row(6'd30, 8'd64));
      add_row(csr_row(pstm_pkg::CSR_PAD_ENABLE_MASK, 48'h5555_5555_5555));
      add_row(fixed_row(6'd1, 8'd80, 1'b0, 1'b0, 7'd0));
      add_row(model_row(6'd2, 8'd80));
      add_row(csr_row(pstm_pkg::CSR_KEY_ROOT, 48'd15));
      add_row(csr_row(pstm_pkg::CSR_BASE_OCTAVE, 48'd15));
      add_row(fixed_row(6'd0, 8'd200, 1'b1, 1'b1, pstm_pkg::NOTE_MAX));
      add_row(fixed_row(6'd46, 8'd0, 1'b1, 1'b0, pstm_pkg::NOTE_MAX));
      add_row(csr_row(pstm_pkg::CSR_KEY_ROOT, 48'd0));
      add_row(csr_row(pstm_pkg::CSR_BASE_OCTAVE, 48'd0));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'(pstm_pkg::MODE_LAST_ROTATION)));
      add_row(fixed_row(6'd0, 8'd200, 1'b1, 1'b1, 7'd0));
      add_row(model_row(6'd44, 8'd33));
      add_row(csr_row(pstm_pkg::CSR_PAD_ENABLE_MASK, '1));
      add_row(csr_row(pstm_pkg::CSR_KEY_ROOT, 48'd11));
      add_row(csr_row(pstm_pkg::CSR_BASE_OCTAVE, 48'd9));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'(pstm_pkg::MODE_NAT_MINOR)));
      add_row(model_row(6'd20, 8'd5));
      add_row(model_row(6'd47, 8'd90));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'(pstm_pkg::MODE_HARM_MINOR)));
      add_row(model_row(6'd13, 8'd70));
      add_row(model_row(6'd47, 8'd0));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'(pstm_pkg::MODE_MEL_MINOR)));
      add_row(model_row(6'd22, 8'd1));
      add_row(model_row(6'd47, 8'd128));
      // undefined mode falls back to major
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'd12));
      add_row(model_row(6'd5, 8'd255));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'd3));
      add_row(model_row(6'd31, 8'd99));
      add_row(csr_row(pstm_pkg::CSR_SCALE_MODE, 48'd15));
      add_row(model_row(6'd47, 8'd255));

      // Hold reset at the start, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle();
            write_reg(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            send_pad(dir_rows[i].pad, dir_rows[i].vel, dir_rows[i].kind == ROW_FIXED,
                     dir_rows[i].has_note, dir_rows[i].msg);
         end
      end

      // Random phases, each under a fresh setting; the first two are the extremes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         idle_on = (ph % 3 != 2);
         if (ph == 0) begin
            write_reg(pstm_pkg::CSR_KEY_ROOT, 48'd15);
            write_reg(pstm_pkg::CSR_SCALE_MODE, 48'd15);
            write_reg(pstm_pkg::CSR_BASE_OCTAVE, 48'd15);
            write_reg(pstm_pkg::CSR_PAD_ENABLE_MASK, '1);
         end else if (ph == 1) begin
            write_reg(pstm_pkg::CSR_KEY_ROOT, 48'd0);
            write_reg(pstm_pkg::CSR_SCALE_MODE, 48'd0);
            write_reg(pstm_pkg::CSR_BASE_OCTAVE, 48'd0);
            write_reg(pstm_pkg::CSR_PAD_ENABLE_MASK, '1);
         end else begin
            write_reg(pstm_pkg::CSR_KEY_ROOT,
                      48'($urandom_range(0, 4) == 0 ? $urandom_range(12, 15)
                                                    : $urandom_range(0, 11)));
            write_reg(pstm_pkg::CSR_SCALE_MODE, 48'($urandom_range(0, 15)));
            write_reg(pstm_pkg::CSR_BASE_OCTAVE,
                      48'($urandom_range(0, 4) == 0 ? $urandom_range(10, 15)
                                                    : $urandom_range(0, 9)));
            mask = pstm_pkg::MASK_W'({$urandom, $urandom});
            if ($urandom_range(0, 5) == 0) mask = '1;
            else if ($urandom_range(0, 9) == 0) mask = '0;
            write_reg(pstm_pkg::CSR_PAD_ENABLE_MASK, mask);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pad = ($urandom_range(0, 9) == 0) ? pstm_pkg::PAD_W'($urandom_range(48, 63))
                                              : pstm_pkg::PAD_W'($urandom_range(0, 47));
            vel = ($urandom_range(0, 3) == 0) ? '0 : pstm_pkg::VEL_W'($urandom_range(0, 255));
            send_pad(pad, vel, 1'b0, 1'b0, '0);
         end
      end

      settle();
      errors += pending_notes.size();
      if (errors == 0)
         $display("** pad_to_scale_note_mapper: PASSED **");
      else
         $display("** pad_to_scale_note_mapper: FAILED **");
      $finish;
   end

endmodule
